// ----- sv/mmp_pkg.sv -----
// Shared types and constants for the 2x2 modular matrix power block.
package mmp_pkg;

  localparam int VAL_W = 30;

  localparam logic [VAL_W-1:0] PRIME = 30'd1000000007;
  localparam logic [31:0] PRIME_X1 = 32'd1000000007;
  localparam logic [31:0] PRIME_X2 = 32'd2000000014;

  // Barrett factor floor(2^60 / P); it fits in 31 bits.
  localparam logic [61:0] MU_FULL = (62'd1 << 60) / 62'd1000000007;
  localparam logic [30:0] MU = 31'(MU_FULL);

  typedef struct packed {
    logic [VAL_W-1:0] tl;
    logic [VAL_W-1:0] tr;
    logic [VAL_W-1:0] bl;
    logic [VAL_W-1:0] br;
  } mat_t;

  // Destination of one product: final product, or matrix, entry and term.
  typedef struct packed {
    logic       fin;
    logic       sq_dest;
    logic [1:0] entry;
    logic       term;
  } tag_t;

  typedef struct packed {
    logic             valid;
    tag_t             tag;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } req_t;

  typedef struct packed {
    logic             valid;
    tag_t             tag;
    logic [VAL_W-1:0] value;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FIN_ISSUE,
    ST_FIN_WAIT,
    ST_DONE
  } state_t;

endpackage

// ----- sv/mmp_mulmod.sv -----
// Pipelined modular multiplier with Barrett reduction, one product per cycle.
module mmp_mulmod (
  input  logic          clk,
  input  logic          rst,
  input  mmp_pkg::req_t req,
  output mmp_pkg::rsp_t rsp,
  output logic          busy
);

  localparam int VAL_W_L = mmp_pkg::VAL_W;

  logic             v1, v2, v3, v4;
  mmp_pkg::tag_t    t1, t2, t3, t4;
  logic [59:0]      p1;
  logic [31:0]      p2, p3, r4;
  logic [61:0]      m2;
  logic [31:0]      qp3;
  logic [60:0]      qp_full;
  logic [VAL_W_L-1:0] fin_val;

  assign qp_full = m2[61:31] * mmp_pkg::PRIME;

  always_comb begin
    if (r4 >= mmp_pkg::PRIME_X2) begin
      fin_val = VAL_W_L'(r4 - mmp_pkg::PRIME_X2);
    end else if (r4 >= mmp_pkg::PRIME_X1) begin
      fin_val = VAL_W_L'(r4 - mmp_pkg::PRIME_X1);
    end else begin
      fin_val = VAL_W_L'(r4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      rsp.valid <= v4;
    end
    t1 <= req.tag;
    t2 <= t1;
    t3 <= t2;
    t4 <= t3;
    rsp.tag <= t4;
    p1 <= req.a * req.b;
    m2 <= p1[59:29] * mmp_pkg::MU;
    p2 <= p1[31:0];
    qp3 <= qp_full[31:0];
    p3 <= p2;
    // The true remainder is below 3P, so 32 bits of the difference suffice.
    r4 <= p3 - qp3;
    rsp.value <= fin_val;
  end

  assign busy = v1 | v2 | v3 | v4 | rsp.valid;

endmodule

// ----- sv/mod_matrix_power_2x2_top.sv -----
// Top level: sequencer for square-and-multiply over a shared modular multiplier.
//
// Input channel s_axis carries one exponent per beat. The block raises the
// configured 2x2 base matrix to that power modulo 1000000007 and sends one
// beat on m_axis with the four result entries and the product of the
// top-left and bottom-left entries.
// The base is written through wr_en / wr_index / wr_data; the user must
// write it only while the block is idle, which the block does not enforce;
// reset loads the matrix {{1,1},{1,0}}. Every product goes through one
// five-stage multiplier with Barrett reduction that accepts one product a
// cycle. Exponent bits are handled from the lowest up to the highest set
// bit: a zero bit issues the 8 products of the squaring, a one bit also
// issues the 8 of the accumulating product. The final left-column product
// follows the last bit; exponent zero goes straight to it.
// s_axis_tready is high only while no item is in work. A finished result
// sits in the output register until taken; a new exponent is accepted
// meanwhile, and its result waits until the register is free.
module mod_matrix_power_2x2_top #(
  parameter int EXP_WIDTH = 63,
  localparam int IN_W = ((EXP_WIDTH + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_W-1:0]           s_axis_tdata,  // exponent
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // res_top_left, res_top_right, res_bottom_left, res_bottom_right,
  // left_column_product
  output logic [151:0]              m_axis_tdata,
  input  logic                      wr_en,
  input  logic [1:0]                wr_index,
  input  logic [mmp_pkg::VAL_W-1:0] wr_data
);

  localparam int W = mmp_pkg::VAL_W;
  localparam logic [1:0] REG_TL = 2'd0;
  localparam logic [1:0] REG_TR = 2'd1;
  localparam logic [1:0] REG_BL = 2'd2;
  localparam logic [1:0] REG_BR = 2'd3;
  localparam logic [3:0] JOB_SQ_FIRST = 4'd8;
  localparam logic [3:0] JOB_LAST = 4'd15;

  mmp_pkg::state_t state, state_next;
  mmp_pkg::mat_t   base, acc, sq, nacc, nsq, base_red, mul_src;
  mmp_pkg::req_t   req;
  mmp_pkg::rsp_t   rsp;
  logic            busy;
  logic [EXP_WIDTH-1:0] exp_reg, exp_shift;
  logic [3:0]      job;
  logic [W-1:0]    hold, lcp, sum_mod;
  logic [W:0]      sum;
  logic            in_acc, out_acc, commit, out_load;
  logic [EXP_WIDTH-1:0] exp_in;

  function automatic logic [W-1:0] red(input logic [W-1:0] x);
    red = (x >= mmp_pkg::PRIME) ? W'(x - mmp_pkg::PRIME) : x;
  endfunction

  function automatic logic [W-1:0] pick(input mmp_pkg::mat_t m, input logic [1:0] idx);
    logic [W-1:0] v;
    case (idx)
      2'd0:    v = m.tl;
      2'd1:    v = m.tr;
      2'd2:    v = m.bl;
      default: v = m.br;
    endcase
    pick = v;
  endfunction

  function automatic mmp_pkg::mat_t put(input mmp_pkg::mat_t m, input logic [1:0] idx,
                                        input logic [W-1:0] v);
    mmp_pkg::mat_t r;
    r = m;
    case (idx)
      2'd0:    r.tl = v;
      2'd1:    r.tr = v;
      2'd2:    r.bl = v;
      default: r.br = v;
    endcase
    put = r;
  endfunction

  assign exp_in    = s_axis_tdata[EXP_WIDTH-1:0];
  assign exp_shift = exp_reg >> 1;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_acc   = m_axis_tvalid && m_axis_tready;

  assign base_red.tl = red(base.tl);
  assign base_red.tr = red(base.tr);
  assign base_red.bl = red(base.bl);
  assign base_red.br = red(base.br);

  assign sum     = {1'b0, hold} + {1'b0, rsp.value};
  assign sum_mod = (sum >= {1'b0, mmp_pkg::PRIME}) ? W'(sum - {1'b0, mmp_pkg::PRIME})
                                                   : W'(sum);

  // Job bits: [3] squaring vs. accumulating, [2:1] entry row/column, [0] term.
  assign mul_src = job[3] ? sq : acc;

  always_comb begin
    state_next = state;
    case (state)
      mmp_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = (exp_in == '0) ? mmp_pkg::ST_FIN_ISSUE : mmp_pkg::ST_ISSUE;
        end
      end
      mmp_pkg::ST_ISSUE: begin
        if (job == JOB_LAST) begin
          state_next = mmp_pkg::ST_DRAIN;
        end
      end
      mmp_pkg::ST_DRAIN: begin
        if (!busy) begin
          state_next = (exp_shift == '0) ? mmp_pkg::ST_FIN_ISSUE : mmp_pkg::ST_ISSUE;
        end
      end
      mmp_pkg::ST_FIN_ISSUE: state_next = mmp_pkg::ST_FIN_WAIT;
      mmp_pkg::ST_FIN_WAIT: begin
        if (!busy) begin
          state_next = mmp_pkg::ST_DONE;
        end
      end
      mmp_pkg::ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = mmp_pkg::ST_IDLE;
        end
      end
      default: state_next = mmp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    commit        = 1'b0;
    out_load      = 1'b0;
    req           = '0;
    case (state)
      mmp_pkg::ST_IDLE: s_axis_tready = 1'b1;
      mmp_pkg::ST_ISSUE: begin
        req.valid       = 1'b1;
        req.tag.sq_dest = job[3];
        req.tag.entry   = job[2:1];
        req.tag.term    = job[0];
        req.a           = pick(mul_src, {job[2], job[0]});
        req.b           = pick(sq, {job[0], job[1]});
      end
      mmp_pkg::ST_DRAIN: commit = !busy;
      mmp_pkg::ST_FIN_ISSUE: begin
        req.valid   = 1'b1;
        req.tag.fin = 1'b1;
        req.a       = acc.tl;
        req.b       = acc.bl;
      end
      mmp_pkg::ST_FIN_WAIT: ;
      mmp_pkg::ST_DONE: out_load = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  mmp_mulmod u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .busy (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mmp_pkg::ST_IDLE;
      m_axis_tvalid <= 1'b0;
      base.tl       <= W'(1);
      base.tr       <= W'(1);
      base.bl       <= W'(1);
      base.br       <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (out_acc) begin
        m_axis_tvalid <= 1'b0;
      end
      if (wr_en) begin
        case (wr_index)
          REG_TL:  base.tl <= wr_data;
          REG_TR:  base.tr <= wr_data;
          REG_BL:  base.bl <= wr_data;
          REG_BR:  base.br <= wr_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      exp_reg <= exp_in;
      acc     <= '{tl: W'(1), tr: '0, bl: '0, br: W'(1)};
      sq      <= base_red;
      job     <= exp_in[0] ? '0 : JOB_SQ_FIRST;
    end else if (commit) begin
      exp_reg <= exp_shift;
      sq      <= nsq;
      if (exp_reg[0]) begin
        acc <= nacc;
      end
      job <= exp_shift[0] ? '0 : JOB_SQ_FIRST;
    end else if (req.valid && !req.tag.fin) begin
      job <= job + 4'd1;
    end

    // First term of an entry arrives in the cycle before the second.
    if (rsp.valid) begin
      if (rsp.tag.fin) begin
        lcp <= rsp.value;
      end else if (!rsp.tag.term) begin
        hold <= rsp.value;
      end else if (rsp.tag.sq_dest) begin
        nsq <= put(nsq, rsp.tag.entry, sum_mod);
      end else begin
        nacc <= put(nacc, rsp.tag.entry, sum_mod);
      end
    end

    if (out_load) begin
      m_axis_tdata <= {2'd0, lcp, acc.br, acc.bl, acc.tr, acc.tl};
    end
  end

  a_term_order: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.tag.fin && rsp.tag.term
      |-> $past(rsp.valid && !rsp.tag.fin && !rsp.tag.term))
    else $error("second product term arrived without its first term");

  a_rsp_reduced: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.value < mmp_pkg::PRIME)
    else $error("multiplier result not reduced below the prime");

  a_accept_idle_unit: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |-> !busy)
    else $error("exponent accepted while products were still in flight");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !m_axis_tvalid || m_axis_tready)
    else $error("output register overwritten before its beat was taken");

endmodule
